### hdl/array_append_remove_by_value_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the array append / remove-by-value unit
// Shared concurrent assertion forms, used one per line in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ARRAY_APPEND_REMOVE_BY_VALUE_UNIT_MACROS_SVH
`define ARRAY_APPEND_REMOVE_BY_VALUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AARV_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AARV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/aarv_pkg.sv
// ----------------------------------------------------------------------------
// aarv_pkg
// Constants, codes and controller/datapath interface types of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aarv_pkg;

   localparam int CAPACITY   = 64;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 32;
   localparam int FUNC_W     = 2;
   localparam int KIND_W     = 2;
   localparam int RSP_CNT_W  = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - DATA_W - RSP_CNT_W;

   // Operation codes carried in req_tuser. Code 3 is unused and is answered with a done word.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   // Result kinds carried in rsp_tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_DONE  = 2'd0,
      KIND_ELEM  = 2'd1,
      KIND_FULL  = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load;        // capture the accepted request
      logic     clr_ptr;     // reset read and write pointers
      logic     del_issue;   // delete walk: read entry at rd, advance rd
      logic     del_commit;  // delete walk done: count takes the write pointer
      logic     app_write;   // append: store value at count, count grows
      logic     ro_issue;    // read out: read entry at rd
      logic     emit;        // load the response register
      kind_type emit_kind;
      logic     emit_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              empty;
      logic              rd_end;
      logic              rd_last;
      logic              pend;
      logic              slot_free;
   } sts_type;

endpackage

`default_nettype wire

### hdl/aarv_ram.sv
// ----------------------------------------------------------------------------
// aarv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aarv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hdl/aarv_dpath.sv
// ----------------------------------------------------------------------------
// aarv_dpath
// Element store, count, walk pointers and the response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "array_append_remove_by_value_unit_macros.svh"

module aarv_dpath
   import aarv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [DATA_W-1:0]     req_value,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [KIND_W-1:0]     rsp_tuser,
   output logic                       rsp_tlast
);

   logic [FUNC_W-1:0] func_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [DATA_W-1:0] rsp_elem_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_last_ff;

   logic              keep;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic              ram_re;
   logic [DATA_W-1:0] ram_rdata;

   // A delete walk keeps an entry when it differs from the value.
   assign keep      = pend_ff && (ram_rdata != value_ff);
   assign ram_we    = cmd.app_write || keep;
   assign ram_waddr = cmd.app_write ? count_ff[ADDR_W-1:0] : wr_ff[ADDR_W-1:0];
   assign ram_wdata = cmd.app_write ? value_ff : ram_rdata;
   assign ram_re    = cmd.del_issue || cmd.ro_issue;

   aarv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (rd_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.app_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del_commit) begin
         count_in = wr_ff;
      end

      rd_in = rd_ff;
      if (cmd.clr_ptr) begin
         rd_in = '0;
      end else if (cmd.del_issue || (cmd.emit && cmd.emit_kind == KIND_ELEM)) begin
         rd_in = rd_ff + CNT_W'(1);
      end

      wr_in = wr_ff;
      if (cmd.clr_ptr) begin
         wr_in = '0;
      end else if (keep) begin
         wr_in = wr_ff + CNT_W'(1);
      end

      pend_in = cmd.del_issue;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.emit) begin
         rsp_kind_ff  <= cmd.emit_kind;
         rsp_elem_ff  <= (cmd.emit_kind == KIND_ELEM) ? ram_rdata : '0;
         rsp_count_ff <= count_in;
         rsp_last_ff  <= cmd.emit_last;
      end
   end

   assign sts.func      = func_ff;
   assign sts.full      = count_ff >= CNT_W'(CAPACITY);
   assign sts.empty     = count_ff == '0;
   assign sts.rd_end    = rd_ff == count_ff;
   assign sts.rd_last   = (rd_ff + CNT_W'(1)) == count_ff;
   assign sts.pend      = pend_ff;
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), RSP_CNT_W'(rsp_count_ff), rsp_elem_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `AARV_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count exceeds capacity")
   `AARV_ASSERT_IMPLIES(a_wr_behind_rd, clock, reset, 1'b1, wr_ff <= rd_ff, "delete write pointer passed read pointer")
   `AARV_ASSERT_IMPLIES(a_append_room, clock, reset, cmd.app_write, !sts.full, "append write into a full store")

endmodule

`default_nettype wire

### hdl/aarv_ctrl.sv
// ----------------------------------------------------------------------------
// aarv_ctrl
// Operation sequencer: accepts a request, walks the store, paces results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "array_append_remove_by_value_unit_macros.svh"

module aarv_ctrl
   import aarv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic [FUNC_W-1:0] req_func,
   output logic                   req_tready,
   input  wire sts_type           sts,
   output cmd_type                cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DEL     = 5'b00010,
      ST_RO_READ = 5'b00100,
      ST_RO_EMIT = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load    = 1'b1;
               cmd.clr_ptr = 1'b1;
               if (req_func == FUNC_DELETE) begin
                  state_in = ST_DEL;
               end else if (req_func == FUNC_READ) begin
                  state_in = ST_RO_READ;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DEL: begin
            // Reads stream one per cycle; kept entries are written in the cycle after their read.
            if (!sts.rd_end) begin
               cmd.del_issue = 1'b1;
            end else if (!sts.pend) begin
               cmd.del_commit = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_RO_READ: begin
            if (sts.empty) begin
               state_in = ST_EMIT;
            end else begin
               cmd.ro_issue = 1'b1;
               state_in     = ST_RO_EMIT;
            end
         end
         ST_RO_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_ELEM;
               cmd.emit_last = sts.rd_last;
               state_in      = sts.rd_last ? ST_IDLE : ST_RO_READ;
            end
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               if (sts.func == FUNC_APPEND) begin
                  cmd.emit_kind = sts.full ? KIND_FULL : KIND_DONE;
                  cmd.app_write = !sts.full;
               end else if (sts.func == FUNC_READ) begin
                  cmd.emit_kind = KIND_EMPTY;
               end else begin
                  cmd.emit_kind = KIND_DONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `AARV_ASSERT_IMPLIES(a_ro_nonempty, clock, reset, state_ff == ST_RO_EMIT, !sts.empty, "read out of an empty store")
   `AARV_ASSERT_IMPLIES(a_emit_free, clock, reset, cmd.emit, sts.slot_free, "response loaded while still held")
   `AARV_ASSERT_NEXT(a_load_leaves_idle, clock, reset, cmd.load, state_ff != ST_IDLE, "request accepted but no work started")

endmodule

`default_nettype wire

### hdl/array_append_remove_by_value_unit.sv
// ----------------------------------------------------------------------------
// array_append_remove_by_value_unit
// Packed store of up to 64 signed words: append, delete-all-equal, read out.
// Requests arrive on req_* (req_tuser = operation, req_tdata = value). Each
// request gives one or more response words on rsp_*, the final one marked by
// rsp_tlast. An append stores its value and returns a done word; a full store
// gives a rejected-full word instead. A delete walks the store through the
// single RAM read port at one entry per cycle, keeping each entry that
// differs from the value, then gives its done word. A read out handles each
// element as a RAM read, then a response load, and gives an empty word when
// nothing is stored. One request is in work at a time; req_tready is high
// only while the unit is idle, and a response waiting in the output register
// does not block the next request. When rsp_tready is low the response
// register holds its word; a read out pauses until it is taken, and a delete
// walk runs to its end and then waits with its done word. Reset clears the
// element count; the RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module array_append_remove_by_value_unit
   import aarv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] value (signed)
   input  wire logic [FUNC_W-1:0]     req_tuser,  // [1:0] func
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] element, [38:32] count, [39] zero
   output logic      [KIND_W-1:0]     rsp_tuser,  // [1:0] kind
   output logic                       rsp_tlast   // last word of this request's run
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each operation; the datapath owns all storage.
   aarv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   aarv_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_tuser),
      .req_value  (req_tdata[DATA_W-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
